// ===== rtl/core/ssi_encoder_reader_top_assert.svh =====
// assertion macros for the ssi encoder reader
`ifndef SSI_ENCODER_READER_TOP_ASSERT_SVH
`define SSI_ENCODER_READER_TOP_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define SSI_RD_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ssi reader check failed");

// consequent must hold in the cycle after the antecedent
`define SSI_RD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ssi reader check failed");

`endif

// ===== rtl/core/ssi_rd_pkg.sv =====
// shared types, codes and constants of the ssi encoder reader
package ssi_rd_pkg;

  localparam int MAX_BITS_DEF = 32;
  localparam int POS_W        = 32;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 32;

  // frame phase codes
  localparam logic [2:0] PH_FRONT = 3'd0;
  localparam logic [2:0] PH_HIGH  = 3'd1;
  localparam logic [2:0] PH_LOW   = 3'd2;
  localparam logic [2:0] PH_BACK  = 3'd3;
  localparam logic [2:0] PH_GAP   = 3'd4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_BITS    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HALF_PERIOD   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FRONT_PERIODS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BACK_PERIODS  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_POLL_GAP      = 3'd4;

  // register reset values
  localparam logic [5:0]  RST_FRAME_BITS    = 6'd24;
  localparam logic [15:0] RST_HALF_PERIOD   = 16'd4096;
  localparam logic [7:0]  RST_FRONT_PERIODS = 8'd1;
  localparam logic [7:0]  RST_BACK_PERIODS  = 8'd1;
  localparam logic [23:0] RST_POLL_GAP      = 24'd50000;

  typedef struct packed {
    logic [5:0]  frame_bits;
    logic [15:0] half_period;
    logic [7:0]  front_periods;
    logic [7:0]  back_periods;
    logic [23:0] poll_gap;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  phase;
    logic [15:0] tick_count;
    logic [7:0]  period_count;
    logic [5:0]  bit_index;
    logic [23:0] gap_count;
  } state_t;

  typedef struct packed {
    logic clock_line;
    logic position_new;
    logic busy_res;
  } flags_t;

endpackage

// ===== rtl/core/ssi_rd_step.sv =====
// next-state logic of the ssi frame sequencer for one timing tick
module ssi_rd_step #(
  parameter int MaxBits = ssi_rd_pkg::MAX_BITS_DEF
) (
  input  ssi_rd_pkg::cfg_t     cfg_i,
  input  ssi_rd_pkg::state_t   st_i,
  input  logic [MaxBits-1:0]   shift_i,
  input  logic [MaxBits-1:0]   latched_i,
  input  logic                 data_line_i,
  output ssi_rd_pkg::state_t   st_o,
  output logic [MaxBits-1:0]   shift_o,
  output logic [MaxBits-1:0]   latched_o,
  output ssi_rd_pkg::flags_t   flags_o
);

  logic [5:0]         eff_bits;
  logic [15:0]        eff_half;
  logic [MaxBits-1:0] mask;

  always_comb begin
    if (cfg_i.frame_bits == 6'd0) begin
      eff_bits = 6'd1;
    end else if (int'(cfg_i.frame_bits) > MaxBits) begin
      eff_bits = 6'(MaxBits);
    end else begin
      eff_bits = cfg_i.frame_bits;
    end
    eff_half = (cfg_i.half_period == 16'd0) ? 16'd1 : cfg_i.half_period;
    for (int i = 0; i < MaxBits; i++) begin
      mask[i] = (i < int'(eff_bits));
    end
  end

  always_comb begin
    ssi_rd_pkg::state_t s;
    logic [MaxBits-1:0] sw;
    logic [MaxBits-1:0] lp;
    logic [15:0]        tn;
    logic               done;
    logic [5:0]         bn;
    s       = st_i;
    sw      = shift_i;
    lp      = latched_i;
    flags_o = '{clock_line: 1'b1, position_new: 1'b0, busy_res: 1'b1};

    // back delay over: latch the word
    if (s.phase == ssi_rd_pkg::PH_BACK && s.period_count >= cfg_i.back_periods) begin
      lp                   = sw & mask;
      flags_o.position_new = 1'b1;
      s.phase              = ssi_rd_pkg::PH_GAP;
      s.gap_count          = '0;
    end
    // gap over, or unknown phase: new frame
    if ((s.phase == ssi_rd_pkg::PH_GAP && s.gap_count >= cfg_i.poll_gap) ||
        s.phase > ssi_rd_pkg::PH_GAP) begin
      s.phase        = ssi_rd_pkg::PH_FRONT;
      s.tick_count   = '0;
      s.period_count = '0;
      s.bit_index    = '0;
      sw             = '0;
    end
    // front delay over: first bit
    if (s.phase == ssi_rd_pkg::PH_FRONT && s.period_count >= cfg_i.front_periods) begin
      s.phase      = ssi_rd_pkg::PH_HIGH;
      s.tick_count = '0;
    end

    tn   = s.tick_count + 16'd1;
    done = (tn >= eff_half) || (tn == 16'd0);
    bn   = s.bit_index + 6'd1;

    unique case (s.phase)
      ssi_rd_pkg::PH_FRONT, ssi_rd_pkg::PH_BACK: begin
        flags_o.clock_line = 1'b0;
        s.tick_count       = done ? 16'd0 : tn;
        if (done) begin
          s.period_count = s.period_count + 8'd1;
        end
      end
      ssi_rd_pkg::PH_HIGH: begin
        s.tick_count = done ? 16'd0 : tn;
        if (done) begin
          sw      = (sw << 1) | MaxBits'(data_line_i);
          s.phase = ssi_rd_pkg::PH_LOW;
        end
      end
      ssi_rd_pkg::PH_LOW: begin
        flags_o.clock_line = 1'b0;
        s.tick_count       = done ? 16'd0 : tn;
        if (done) begin
          s.bit_index = bn;
          if (bn >= eff_bits || bn == 6'd0) begin
            s.phase        = ssi_rd_pkg::PH_BACK;
            s.period_count = '0;
          end else begin
            s.phase = ssi_rd_pkg::PH_HIGH;
          end
        end
      end
      default: begin
        // idle gap with clock high
        flags_o.busy_res = 1'b0;
        s.gap_count      = s.gap_count + 24'd1;
      end
    endcase

    st_o      = s;
    shift_o   = sw;
    latched_o = lp;
  end

endmodule

// ===== rtl/core/ssi_encoder_reader_top.sv =====
// a tick accepted at a clock edge is loaded into the result register at that
//   same edge and offered on the output from the following cycle
// throughput: one tick per cycle while the result register is not stalled, the single next-state
//   pass in ssi_rd_step between the frame state registers and the result register sets this figure
// output register drains while a new tick enters, stall rises only when it is full and held
// reset: registers to their defaults, sequencer at frame start with counters and position
//   cleared, result register empty; the first frame begins with the first accepted tick
`include "ssi_encoder_reader_top_assert.svh"

module ssi_encoder_reader_top #(
  parameter int MaxBits = ssi_rd_pkg::MAX_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // tick input channel
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              data_line_i,
  // result channel
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic                              clock_line_o,
  output logic [ssi_rd_pkg::POS_W-1:0]      position_o,
  output logic                              position_new_o,
  output logic                              busy_res_o,
  // configuration write channel
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [ssi_rd_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [ssi_rd_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  localparam int PosW = ssi_rd_pkg::POS_W;

  ssi_rd_pkg::cfg_t   cfg_q;
  ssi_rd_pkg::state_t st_q, st_d;
  logic [MaxBits-1:0] shift_q, shift_d;
  logic [MaxBits-1:0] latched_q, latched_d;
  ssi_rd_pkg::flags_t flags_d;

  logic               out_valid_q;
  logic               clock_line_q, position_new_q, busy_res_q;
  logic [PosW-1:0]    position_q;
  logic               in_accept;

  // the result register takes a new tick whenever it is empty or being drained
  assign in_stall_o  = out_valid_q & out_stall_i;
  assign in_accept   = in_valid_i & ~in_stall_o;
  assign cfg_ready_o = 1'b1;

  // configuration registers, every transaction accepted at once
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.frame_bits    <= ssi_rd_pkg::RST_FRAME_BITS;
      cfg_q.half_period   <= ssi_rd_pkg::RST_HALF_PERIOD;
      cfg_q.front_periods <= ssi_rd_pkg::RST_FRONT_PERIODS;
      cfg_q.back_periods  <= ssi_rd_pkg::RST_BACK_PERIODS;
      cfg_q.poll_gap      <= ssi_rd_pkg::RST_POLL_GAP;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        ssi_rd_pkg::REG_FRAME_BITS:    cfg_q.frame_bits    <= cfg_data_i[5:0];
        ssi_rd_pkg::REG_HALF_PERIOD:   cfg_q.half_period   <= cfg_data_i[15:0];
        ssi_rd_pkg::REG_FRONT_PERIODS: cfg_q.front_periods <= cfg_data_i[7:0];
        ssi_rd_pkg::REG_BACK_PERIODS:  cfg_q.back_periods  <= cfg_data_i[7:0];
        ssi_rd_pkg::REG_POLL_GAP:      cfg_q.poll_gap      <= cfg_data_i[23:0];
        default: ; // writes to unused indexes are dropped
      endcase
    end
  end

  // frame sequencer: one tick of next-state logic
  ssi_rd_step #(
    .MaxBits (MaxBits)
  ) u_step (
    .cfg_i       (cfg_q),
    .st_i        (st_q),
    .shift_i     (shift_q),
    .latched_i   (latched_q),
    .data_line_i (data_line_i),
    .st_o        (st_d),
    .shift_o     (shift_d),
    .latched_o   (latched_d),
    .flags_o     (flags_d)
  );

  // sequencer state, advances only on an accepted tick
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q.phase        <= ssi_rd_pkg::PH_FRONT;
      st_q.tick_count   <= '0;
      st_q.period_count <= '0;
      st_q.bit_index    <= '0;
      st_q.gap_count    <= '0;
      shift_q           <= '0;
      latched_q         <= '0;
    end else if (in_accept) begin
      st_q      <= st_d;
      shift_q   <= shift_d;
      latched_q <= latched_d;
    end
  end

  // result register valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_accept) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // result payload, held while stalled
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      clock_line_q   <= flags_d.clock_line;
      position_new_q <= flags_d.position_new;
      busy_res_q     <= flags_d.busy_res;
      position_q     <= PosW'(latched_d);
    end
  end

  assign out_valid_o    = out_valid_q;
  assign clock_line_o   = clock_line_q;
  assign position_o     = position_q;
  assign position_new_o = position_new_q;
  assign busy_res_o     = busy_res_q;

  // checks on the sequencer and result register
  `SSI_RD_ASSERT_NEXT(a_accept_gives_result, in_accept, out_valid_q)
  `SSI_RD_ASSERT_SAME(a_stall_only_when_full, in_stall_o, out_valid_q)
  `SSI_RD_ASSERT_SAME(a_idle_clock_high, out_valid_q && !busy_res_q, clock_line_q)
  `SSI_RD_ASSERT_SAME(a_bit_index_bounded, 1'b1, int'(st_q.bit_index) <= MaxBits)

endmodule

// ===== tb/ssi_encoder_reader_top_tb.sv =====
// self-checking testbench for the ssi encoder reader: tick driver, result monitor, predictor
module ssi_encoder_reader_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [ssi_rd_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 60;

  typedef struct packed {
    logic                        clock_line;
    logic [ssi_rd_pkg::POS_W-1:0] position;
    logic                        position_new;
    logic                        busy_res;
  } pin_readout_t;

  logic                              clk_i = 1'b0;
  logic                              rst_ni = 1'b0;
  logic                              in_valid_i = 1'b0;
  logic                              in_stall_o;
  logic                              data_line_i = 1'b0;
  logic                              out_valid_o;
  logic                              out_stall_i = 1'b0;
  logic                              clock_line_o;
  logic [ssi_rd_pkg::POS_W-1:0]      position_o;
  logic                              position_new_o;
  logic                              busy_res_o;
  logic                              cfg_valid_i = 1'b0;
  logic                              cfg_ready_o;
  logic [ssi_rd_pkg::CFG_IDX_W-1:0]  cfg_index_i = ssi_rd_pkg::REG_FRAME_BITS;
  logic [ssi_rd_pkg::CFG_DATA_W-1:0] cfg_data_i = '0;

  // data line samples waiting to be offered, and readouts still to come back
  logic         data_line_q[$];
  pin_readout_t predicted_pins[$];

  // sequencer copy used for prediction
  ssi_rd_pkg::cfg_t             enc_cfg;
  ssi_rd_pkg::state_t           seq;
  logic [ssi_rd_pkg::POS_W-1:0] shift_word;
  logic [ssi_rd_pkg::POS_W-1:0] latched_pos;

  int   idle_mode = 0;  // 0: sender light, receiver heavy; 1: swapped; 2: no idling
  logic tick_taken;
  int   ticks_taken;
  int   mismatch_count = 0;
  int   cycle_count = 0;

  ssi_encoder_reader_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .data_line_i    (data_line_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .clock_line_o   (clock_line_o),
    .position_o     (position_o),
    .position_new_o (position_new_o),
    .busy_res_o     (busy_res_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  always #4ns clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------------

  // frame length with zero and oversize values clamped
  function automatic logic [5:0] word_bits();
    if (enc_cfg.frame_bits == 6'd0) begin
      return 6'd1;
    end
    if (enc_cfg.frame_bits > ssi_rd_pkg::MAX_BITS_DEF) begin
      return 6'(ssi_rd_pkg::MAX_BITS_DEF);
    end
    return enc_cfg.frame_bits;
  endfunction

  function automatic void restart_frame();
    seq.phase        = ssi_rd_pkg::PH_FRONT;
    seq.tick_count   = '0;
    seq.period_count = '0;
    seq.bit_index    = '0;
    shift_word       = '0;
  endfunction

  // one tick of a half-period, true when the half-period has run out
  function automatic logic half_elapsed();
    logic [15:0] lim;
    lim = (enc_cfg.half_period == 16'd0) ? 16'd1 : enc_cfg.half_period;
    seq.tick_count = seq.tick_count + 16'd1;
    if (seq.tick_count >= lim || seq.tick_count == 16'd0) begin
      seq.tick_count = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic clock_encoder_tick(input logic din, output pin_readout_t res);
    logic                         settled;
    logic [5:0]                   nb;
    logic [ssi_rd_pkg::POS_W-1:0] mask;
    res.clock_line   = 1'b1;
    res.busy_res     = 1'b1;
    res.position_new = 1'b0;
    settled          = 1'b0;
    // phases that have run out are left within the same tick
    for (int k = 0; k < 4 && !settled; k++) begin
      if (seq.phase == ssi_rd_pkg::PH_FRONT &&
          seq.period_count >= enc_cfg.front_periods) begin
        seq.phase      = ssi_rd_pkg::PH_HIGH;
        seq.tick_count = '0;
      end else if (seq.phase == ssi_rd_pkg::PH_BACK &&
                   seq.period_count >= enc_cfg.back_periods) begin
        nb               = word_bits();
        mask             = (nb >= 6'd32) ? '1 : ((32'd1 << nb) - 32'd1);
        latched_pos      = shift_word & mask;
        res.position_new = 1'b1;
        seq.phase        = ssi_rd_pkg::PH_GAP;
        seq.gap_count    = '0;
      end else if (seq.phase == ssi_rd_pkg::PH_GAP && seq.gap_count >= enc_cfg.poll_gap) begin
        restart_frame();
      end else if (seq.phase > ssi_rd_pkg::PH_GAP) begin
        restart_frame();
      end else begin
        settled = 1'b1;
      end
    end
    case (seq.phase)
      ssi_rd_pkg::PH_FRONT, ssi_rd_pkg::PH_BACK: begin
        res.clock_line = 1'b0;
        if (half_elapsed()) begin
          seq.period_count = seq.period_count + 8'd1;
        end
      end
      ssi_rd_pkg::PH_HIGH: begin
        if (half_elapsed()) begin
          shift_word = {shift_word[ssi_rd_pkg::POS_W-2:0], din};
          seq.phase  = ssi_rd_pkg::PH_LOW;
        end
      end
      ssi_rd_pkg::PH_LOW: begin
        res.clock_line = 1'b0;
        if (half_elapsed()) begin
          seq.bit_index = seq.bit_index + 6'd1;
          if (seq.bit_index >= word_bits() || seq.bit_index == 6'd0) begin
            seq.phase        = ssi_rd_pkg::PH_BACK;
            seq.period_count = '0;
          end else begin
            seq.phase = ssi_rd_pkg::PH_HIGH;
          end
        end
      end
      default: begin
        res.busy_res  = 1'b0;
        seq.gap_count = seq.gap_count + 24'd1;
      end
    endcase
    res.position = latched_pos;
  endtask

  // ---------------------------------------------------------------------------
  // monitor: checks results, follows register writes, predicts each tick
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    pin_readout_t want;
    pin_readout_t got;
    if (!rst_ni) begin
      enc_cfg = '{frame_bits: ssi_rd_pkg::RST_FRAME_BITS,
                  half_period: ssi_rd_pkg::RST_HALF_PERIOD,
                  front_periods: ssi_rd_pkg::RST_FRONT_PERIODS,
                  back_periods: ssi_rd_pkg::RST_BACK_PERIODS,
                  poll_gap: ssi_rd_pkg::RST_POLL_GAP};
      seq         = '0;
      latched_pos = '0;
      restart_frame();
      predicted_pins.delete();
      tick_taken  <= 1'b0;
      ticks_taken <= 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (predicted_pins.size() == 0) begin
          $error("result transaction with no tick outstanding");
          mismatch_count++;
        end else begin
          want = predicted_pins.pop_front();
          if (clock_line_o !== want.clock_line) begin
            $error("clock_line: expected %0b, got %0b", want.clock_line, clock_line_o);
            mismatch_count++;
          end
          if (position_o !== want.position) begin
            $error("position: expected %08h, got %08h", want.position, position_o);
            mismatch_count++;
          end
          if (position_new_o !== want.position_new) begin
            $error("position_new: expected %0b, got %0b", want.position_new, position_new_o);
            mismatch_count++;
          end
          if (busy_res_o !== want.busy_res) begin
            $error("busy_res: expected %0b, got %0b", want.busy_res, busy_res_o);
            mismatch_count++;
          end
        end
      end
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          ssi_rd_pkg::REG_FRAME_BITS:    enc_cfg.frame_bits    = cfg_data_i[5:0];
          ssi_rd_pkg::REG_HALF_PERIOD:   enc_cfg.half_period   = cfg_data_i[15:0];
          ssi_rd_pkg::REG_FRONT_PERIODS: enc_cfg.front_periods = cfg_data_i[7:0];
          ssi_rd_pkg::REG_BACK_PERIODS:  enc_cfg.back_periods  = cfg_data_i[7:0];
          ssi_rd_pkg::REG_POLL_GAP:      enc_cfg.poll_gap      = cfg_data_i[23:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_o) begin
        clock_encoder_tick(data_line_i, got);
        predicted_pins.push_back(got);
        ticks_taken <= ticks_taken + 1;
      end
      tick_taken <= in_valid_i && !in_stall_o;
    end
  end

  // ---------------------------------------------------------------------------
  // tick driver: holds a transaction until it is taken, idles at random
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || tick_taken) begin
      if (data_line_q.size() != 0 &&
          !(idle_mode == 0 && $urandom_range(99) < 11) &&
          !(idle_mode == 1 && $urandom_range(99) < 76)) begin
        in_valid_i  <= 1'b1;
        data_line_i <= data_line_q.pop_front();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // receiver: random stalls, plus one long hold-off so the block backs up
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    int   hold_left;
    logic hold_done;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      hold_left = 0;
      hold_done = 1'b0;
    end else if (hold_left != 0) begin
      out_stall_i <= 1'b1;
      hold_left--;
    end else if (!hold_done && idle_mode == 2 && ticks_taken >= 380 && in_valid_i) begin
      out_stall_i <= 1'b1;
      hold_left = HOLD_CYCLES;
      hold_done = 1'b1;
    end else begin
      out_stall_i <= (idle_mode == 0 && $urandom_range(99) < 76) ||
                     (idle_mode == 1 && $urandom_range(99) < 11);
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------

  // wait until every tick has been taken and every readout has come back
  task automatic wait_drained();
    while (data_line_q.size() != 0 || in_valid_i || predicted_pins.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (2) @(posedge clk_i);
  endtask

  // one register write transaction, with junk above the field width half the time
  task automatic write_reg(input logic [ssi_rd_pkg::CFG_IDX_W-1:0] idx,
                           input logic [31:0] value, input int width);
    logic [31:0] word;
    word = value;
    if (width < 32 && $urandom_range(1) == 1) begin
      word = word | ($urandom() << width);
    end
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= word;
    do begin
      @(posedge clk_i);
    end while (!cfg_ready_o);
  endtask

  task automatic program_setting(input int bits, input int half, input int front,
                                 input int back, input int gap);
    write_reg(ssi_rd_pkg::REG_FRAME_BITS, bits, 6);
    write_reg(ssi_rd_pkg::REG_HALF_PERIOD, half, 16);
    write_reg(ssi_rd_pkg::REG_FRONT_PERIODS, front, 8);
    write_reg(ssi_rd_pkg::REG_BACK_PERIODS, back, 8);
    write_reg(ssi_rd_pkg::REG_POLL_GAP, gap, 24);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    int bits;
    int half;
    int front;
    int back;
    int gap;
    int n;
    int style;
    int total;
    int phase_no;
    int eff_half;
    int eff_bits;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: a few ticks into the front delay
    for (int i = 0; i < 6; i++) begin
      data_line_q.push_back(i[0]);
    end
    wait_drained();

    // unused index, oversize frame, zero half-period and every delay zero
    write_reg(REG_UNUSED, $urandom(), 32);
    program_setting(63, 0, 0, 0, 0);
    for (int i = 0; i < 19; i++) begin
      data_line_q.push_back(1'b1);
    end
    total    = 25;
    phase_no = 0;

    while (total < 525) begin
      if (total >= 366) begin
        idle_mode = 2;
      end else if (total >= 183) begin
        idle_mode = 1;
      end
      case ($urandom_range(9))
        0:       bits = 0;
        1:       bits = 32;
        2:       bits = $urandom_range(33, 63);
        default: bits = $urandom_range(1, 8);
      endcase
      half  = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 3);
      front = ($urandom_range(9) < 3) ? 0 : $urandom_range(1, 3);
      back  = ($urandom_range(9) < 3) ? 0 : $urandom_range(1, 3);
      gap   = ($urandom_range(9) < 3) ? 0 : $urandom_range(1, 8);
      eff_bits = (bits == 0) ? 1 : ((bits > 32) ? 32 : bits);
      if (eff_bits > 16) begin
        half = $urandom_range(1);
      end
      eff_half = (half == 0) ? 1 : half;
      n = (front + back) * eff_half + 2 * eff_bits * eff_half + gap + 8;
      n = (n < 12) ? 12 : ((n > 110) ? 110 : n);

      // ceiling settings, a short look each; the next setting shortens them again
      if (phase_no == 3) begin
        bits = 32;
        half = 65535;
        n    = 12;
      end else if (phase_no == 8) begin
        bits  = 40;
        half  = 2;
        front = 255;
        back  = 255;
        gap   = 24'hFFFFFF;
        n     = 12;
      end

      wait_drained();
      program_setting(bits, half, front, back, gap);
      style = $urandom_range(5);
      for (int i = 0; i < n; i++) begin
        data_line_q.push_back((style == 0) ? 1'b0 : ((style == 1) ? 1'b1 : 1'($urandom())));
      end
      total += n;
      phase_no++;
    end

    wait_drained();
    repeat (4) @(posedge clk_i);
    if (mismatch_count == 0 && predicted_pins.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== ssi_encoder_reader_top.f =====
+incdir+rtl/core
rtl/core/ssi_rd_pkg.sv
rtl/core/ssi_rd_step.sv
rtl/core/ssi_encoder_reader_top.sv
tb/ssi_encoder_reader_top_tb.sv
